### rtl/hrhp_pkg.sv
package hrhp_pkg;

  localparam int MAX_HEADER_BYTES = 8191;
  localparam int URI_LIMIT = 64;
  localparam int ID_LIMIT = 255;
  localparam int HC_W = 13;
  localparam int UC_W = 7;
  localparam int IC_W = 8;
  localparam int LEN_W = 31;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_REQ = 3'd2;
  localparam logic [2:0] PH_FIELDS = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic [2:0] LM_START = 3'd0;
  localparam logic [2:0] LM_KW_CL = 3'd1;
  localparam logic [2:0] LM_KW_ID = 3'd2;
  localparam logic [2:0] LM_CL_WS = 3'd3;
  localparam logic [2:0] LM_CL_DIG = 3'd4;
  localparam logic [2:0] LM_ID_WS = 3'd5;
  localparam logic [2:0] LM_ID_VAL = 3'd6;
  localparam logic [2:0] LM_SKIP = 3'd7;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_URI = 3'd1;
  localparam logic [2:0] KIND_ID = 3'd2;
  localparam logic [2:0] KIND_BODY = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;
  localparam logic [2:0] KIND_ID_FIRST = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_LINE = 3'd1;
  localparam logic [2:0] ST_BAD_METHOD = 3'd2;
  localparam logic [2:0] ST_BAD_URI = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_CLOSED = 3'd5;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic start_request;
    logic stream_closed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_kind;
    logic header_done;
    logic [2:0] parse_status;
    logic is_put;
    logic [LEN_W-1:0] body_length;
    logic request_last;
  } out_item_t;

  function automatic logic [7:0] kw_len_char(input logic [4:0] i);
    case (i)
      5'd0: kw_len_char = "c";
      5'd1: kw_len_char = "o";
      5'd2: kw_len_char = "n";
      5'd3: kw_len_char = "t";
      5'd4: kw_len_char = "e";
      5'd5: kw_len_char = "n";
      5'd6: kw_len_char = "t";
      5'd7: kw_len_char = "-";
      5'd8: kw_len_char = "l";
      5'd9: kw_len_char = "e";
      5'd10: kw_len_char = "n";
      5'd11: kw_len_char = "g";
      5'd12: kw_len_char = "t";
      5'd13: kw_len_char = "h";
      5'd14: kw_len_char = ":";
      default: kw_len_char = 8'hff;
    endcase
  endfunction

  function automatic logic [7:0] kw_id_char(input logic [4:0] i);
    case (i)
      5'd0: kw_id_char = "r";
      5'd1: kw_id_char = "e";
      5'd2: kw_id_char = "q";
      5'd3: kw_id_char = "u";
      5'd4: kw_id_char = "e";
      5'd5: kw_id_char = "s";
      5'd6: kw_id_char = "t";
      5'd7: kw_id_char = "-";
      5'd8: kw_id_char = "i";
      5'd9: kw_id_char = "d";
      5'd10: kw_id_char = ":";
      default: kw_id_char = 8'hff;
    endcase
  endfunction

endpackage

### rtl/hrhp_queue.sv
module hrhp_queue
  import hrhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output in_item_t  head
);

  in_item_t slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### rtl/hrhp_engine.sv
module hrhp_engine
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  in_item_t   item,
  output logic       item_take,
  output logic       res_valid,
  output out_item_t  res,
  input  logic       res_stall
);

  logic [2:0] phase, phase_next;
  logic [1:0] terminator_match, terminator_match_next;
  logic [1:0] token_index, token_index_next;
  logic [2:0] method_match, method_match_next;
  logic [UC_W-1:0] uri_count, uri_count_next;
  logic [4:0] keyword_position, keyword_position_next;
  logic [LEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [IC_W-1:0] id_count, id_count_next;
  logic [HC_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0] body_remaining, body_remaining_next;
  logic [2:0] error_flags, error_flags_next;
  logic in_token, in_token_next;
  logic [2:0] line_mode, line_mode_next;
  logic minus_seen, minus_seen_next;
  logic [LEN_W-1:0] committed_len, committed_len_next;
  logic put_flag, put_flag_next;
  out_item_t res_next;

  assign item_take = item_valid && (!res_valid || !res_stall);

  logic [7:0] c, lc;
  logic is_dig, is_brk;
  logic [LEN_W+3:0] acc_x10;
  logic [LEN_W+3:0] acc_new;
  assign c = item.data_byte;
  assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign is_dig = (c >= "0" && c <= "9");
  assign is_brk = (c == 8'd13) || (c == 8'd10);
  assign acc_x10 = {1'b0, length_accumulator, 3'b000} + {3'b000, length_accumulator, 1'b0};
  assign acc_new = acc_x10 + (LEN_W+4)'(c - "0");

  always_comb begin
    logic [2:0] kind;
    logic done;
    logic [2:0] status;
    logic last;
    logic complete;
    logic [2:0] ph;
    logic uri_ok;
    phase_next = phase;
    terminator_match_next = terminator_match;
    token_index_next = token_index;
    method_match_next = method_match;
    uri_count_next = uri_count;
    keyword_position_next = keyword_position;
    length_accumulator_next = length_accumulator;
    id_count_next = id_count;
    header_count_next = header_count;
    body_remaining_next = body_remaining;
    error_flags_next = error_flags;
    in_token_next = in_token;
    line_mode_next = line_mode;
    minus_seen_next = minus_seen;
    committed_len_next = committed_len;
    put_flag_next = put_flag;
    kind = KIND_IGNORED;
    done = 1'b0;
    status = ST_OK;
    last = 1'b0;
    complete = 1'b0;
    uri_ok = 1'b0;
    ph = phase;
    if (item.start_request) begin
      terminator_match_next = '0;
      token_index_next = '0;
      method_match_next = '0;
      uri_count_next = '0;
      keyword_position_next = '0;
      length_accumulator_next = '0;
      id_count_next = '0;
      header_count_next = '0;
      body_remaining_next = '0;
      error_flags_next = '0;
      in_token_next = 1'b0;
      line_mode_next = LM_START;
      minus_seen_next = 1'b0;
      committed_len_next = '0;
      put_flag_next = 1'b0;
      ph = PH_LEAD;
    end
    phase_next = ph;
    if (item.stream_closed) begin
      if (ph >= PH_LEAD && ph <= PH_BODY) begin
        status = ST_CLOSED;
        last = 1'b1;
        phase_next = PH_DONE;
      end
    end else if (ph == PH_BODY) begin
      kind = KIND_BODY;
      if (body_remaining_next == '0 || body_remaining_next == LEN_W'(1)) begin
        body_remaining_next = '0;
        last = 1'b1;
        phase_next = PH_DONE;
      end else begin
        body_remaining_next = body_remaining_next - 1'b1;
      end
    end else if (ph >= PH_LEAD && ph <= PH_FIELDS) begin
      if (ph == PH_LEAD && !is_brk) ph = PH_REQ;
      phase_next = ph;
      kind = KIND_OTHER;
      if (ph == PH_REQ) begin
        if (is_brk || c == " ") begin
          if (in_token_next) begin
            in_token_next = 1'b0;
            if (token_index_next == 2'd1) begin
              if (method_match_next == 3'd3 || method_match_next == 3'd6)
                put_flag_next = (method_match_next == 3'd6);
              else
                error_flags_next[1] = 1'b1;
            end else if (token_index_next == 2'd2) begin
              if (uri_count_next >= UC_W'(URI_LIMIT)) error_flags_next[2] = 1'b1;
            end
          end
          if (is_brk) begin
            if (token_index_next != 2'd3) error_flags_next[0] = 1'b1;
            phase_next = PH_FIELDS;
            line_mode_next = LM_START;
            keyword_position_next = '0;
          end
        end else begin
          if (!in_token_next) begin
            in_token_next = 1'b1;
            if (token_index_next != 2'd3) token_index_next = token_index_next + 1'b1;
          end
          if (token_index_next == 2'd1) begin
            case (method_match_next)
              3'd0: method_match_next = (c == "G") ? 3'd1 : (c == "P") ? 3'd4 : 3'd7;
              3'd1: method_match_next = (c == "E") ? 3'd2 : 3'd7;
              3'd2: method_match_next = (c == "T") ? 3'd3 : 3'd7;
              3'd4: method_match_next = (c == "U") ? 3'd5 : 3'd7;
              3'd5: method_match_next = (c == "T") ? 3'd6 : 3'd7;
              default: method_match_next = 3'd7;
            endcase
          end else if (token_index_next == 2'd2) begin
            kind = KIND_URI;
            uri_ok = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || is_dig ||
                     c == "." || c == "-";
            if (uri_count_next == '0) begin
              if (c != "/") error_flags_next[2] = 1'b1;
            end else if (!uri_ok) begin
              error_flags_next[2] = 1'b1;
            end
            if (uri_count_next < UC_W'(URI_LIMIT)) uri_count_next = uri_count_next + 1'b1;
          end
        end
      end else if (ph == PH_FIELDS) begin
        if (is_brk) begin
          line_mode_next = LM_START;
          keyword_position_next = '0;
        end else begin
          case (line_mode_next)
            LM_START: begin
              if (lc == "c") begin
                line_mode_next = LM_KW_CL;
                keyword_position_next = 5'd1;
              end else if (lc == "r") begin
                line_mode_next = LM_KW_ID;
                keyword_position_next = 5'd1;
              end else begin
                line_mode_next = LM_SKIP;
              end
            end
            LM_KW_CL: begin
              if (keyword_position_next < 5'd15 &&
                  lc == kw_len_char(keyword_position_next)) begin
                keyword_position_next = keyword_position_next + 1'b1;
                if (keyword_position_next == 5'd15) begin
                  line_mode_next = LM_CL_WS;
                  length_accumulator_next = '0;
                  minus_seen_next = 1'b0;
                  committed_len_next = '0;
                end
              end else line_mode_next = LM_SKIP;
            end
            LM_KW_ID: begin
              if (keyword_position_next < 5'd11 &&
                  lc == kw_id_char(keyword_position_next)) begin
                keyword_position_next = keyword_position_next + 1'b1;
                if (keyword_position_next == 5'd11) begin
                  line_mode_next = LM_ID_WS;
                  id_count_next = '0;
                end
              end else line_mode_next = LM_SKIP;
            end
            LM_CL_WS, LM_CL_DIG: begin
              if (line_mode_next == LM_CL_WS &&
                  (c == " " || c == 8'd9 || c == 8'd11 || c == 8'd12)) begin
                line_mode_next = LM_CL_WS;
              end else if (line_mode_next == LM_CL_WS && c == "+") begin
                line_mode_next = LM_CL_DIG;
              end else if (line_mode_next == LM_CL_WS && c == "-") begin
                minus_seen_next = 1'b1;
                line_mode_next = LM_CL_DIG;
              end else if (is_dig) begin
                line_mode_next = LM_CL_DIG;
                if (acc_new > (LEN_W+4)'(LEN_MAX)) length_accumulator_next = LEN_MAX;
                else length_accumulator_next = acc_new[LEN_W-1:0];
                committed_len_next = minus_seen_next ? '0 : length_accumulator_next;
              end else begin
                line_mode_next = LM_SKIP;
              end
            end
            LM_ID_WS, LM_ID_VAL: begin
              if (!(line_mode_next == LM_ID_WS && c == " ")) begin
                line_mode_next = LM_ID_VAL;
                if (id_count_next < IC_W'(ID_LIMIT)) begin
                  kind = (id_count_next == '0) ? KIND_ID_FIRST : KIND_ID;
                  id_count_next = id_count_next + 1'b1;
                end
              end
            end
            default: line_mode_next = LM_SKIP;
          endcase
        end
      end
      if (header_count_next < HC_W'(MAX_HEADER_BYTES))
        header_count_next = header_count_next + 1'b1;
      if (terminator_match_next == 2'd3 && c == 8'd10) complete = 1'b1;
      else if ((terminator_match_next[0] == 1'b0 && c == 8'd13) ||
               (terminator_match_next[0] == 1'b1 && c == 8'd10))
        terminator_match_next = terminator_match_next + 1'b1;
      else terminator_match_next = (c == 8'd13) ? 2'd1 : 2'd0;
      if (complete) begin
        terminator_match_next = '0;
        done = 1'b1;
        if (ph == PH_LEAD || error_flags_next[0]) status = ST_BAD_LINE;
        else if (error_flags_next[1]) status = ST_BAD_METHOD;
        else if (error_flags_next[2]) status = ST_BAD_URI;
        if (status != ST_OK || committed_len_next == '0) begin
          last = 1'b1;
          phase_next = PH_DONE;
        end else begin
          body_remaining_next = committed_len_next;
          phase_next = PH_BODY;
        end
      end else if (header_count_next >= HC_W'(MAX_HEADER_BYTES)) begin
        status = ST_TOO_LONG;
        last = 1'b1;
        phase_next = PH_DONE;
      end
    end
    res_next.byte_out = item.stream_closed ? 8'd0 : c;
    res_next.byte_kind = kind;
    res_next.header_done = done;
    res_next.parse_status = status;
    res_next.is_put = put_flag_next;
    res_next.body_length = committed_len_next;
    res_next.request_last = last;
  end

  always_ff @(posedge clk) begin
    if (item_take) res <= res_next;
    if (rst) begin
      res_valid <= 1'b0;
      phase <= PH_IDLE;
      terminator_match <= '0;
      token_index <= '0;
      method_match <= '0;
      uri_count <= '0;
      keyword_position <= '0;
      length_accumulator <= '0;
      id_count <= '0;
      header_count <= '0;
      body_remaining <= '0;
      error_flags <= '0;
      in_token <= 1'b0;
      line_mode <= LM_START;
      minus_seen <= 1'b0;
      committed_len <= '0;
      put_flag <= 1'b0;
    end else begin
      if (item_take) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
      if (item_take) begin
        phase <= phase_next;
        terminator_match <= terminator_match_next;
        token_index <= token_index_next;
        method_match <= method_match_next;
        uri_count <= uri_count_next;
        keyword_position <= keyword_position_next;
        length_accumulator <= length_accumulator_next;
        id_count <= id_count_next;
        header_count <= header_count_next;
        body_remaining <= body_remaining_next;
        error_flags <= error_flags_next;
        in_token <= in_token_next;
        line_mode <= line_mode_next;
        minus_seen <= minus_seen_next;
        committed_len <= committed_len_next;
        put_flag <= put_flag_next;
      end
    end
  end

endmodule

### rtl/http_request_header_parser.sv
// One received byte per transaction, one result per transaction, sustained at one per cycle:
// while out_stall is low: the input side lands bytes in a four-entry queue and the parse
// engine takes one byte a cycle when no stalled result is held, updating its matchers and
// counters and writing the result into an output register after its queue slot.
module http_request_header_parser
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic q_full, q_empty, q_pop;
  in_item_t q_head;

  assign in_stall = q_full;

  hrhp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_valid && !q_full),
    .push_item(in_data),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .head(q_head)
  );

  hrhp_engine u_engine (
    .clk(clk),
    .rst(rst),
    .item_valid(!q_empty),
    .item(q_head),
    .item_take(q_pop),
    .res_valid(out_valid),
    .res(out_data),
    .res_stall(out_stall)
  );

endmodule
